/* design/mah_pkg.sv */
package mah_pkg;

  localparam int unsigned DEF_GROUP_ENTRIES = 4096;
  localparam int unsigned DEF_COUNTER_BITS  = 32;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned TYPE_W     = 8;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned TOTAL_W    = 34;
  localparam int unsigned BAR_W      = 7;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SLOT_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned SHIFT_W    = 5;

  localparam logic [TYPE_W-1:0]  TYPE_LIMIT    = 8'd64;
  localparam logic [TYPE_W-1:0]  LOW_CODE_MASK = 8'h07;
  localparam int unsigned        SIZE_SHIFT    = 3;
  localparam logic [COUNT_W-1:0] FIELD_MAX     = 32'hffff_ffff;

  localparam logic [TYPE_W-1:0] CODE_FIRST  = 8'd1;
  localparam logic [TYPE_W-1:0] CODE_SECOND = 8'd2;
  localparam logic [TYPE_W-1:0] CODE_THIRD  = 8'd4;

  localparam logic [SLOT_W-1:0] SLOT_FIRST  = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_SECOND = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_THIRD  = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_OUTSIDE = 3'd1,
    ST_OVER    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_BEYOND  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIN_START   = 2'd0,
    CFG_WIN_END     = 2'd1,
    CFG_GROUP_SHIFT = 2'd2,
    CFG_WIDTH_MODE  = 2'd3
  } cfg_reg_t;

  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_READOUT = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic [TYPE_W-1:0] access_type;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count_first;
    logic [COUNT_W-1:0]  count_second;
    logic [COUNT_W-1:0]  count_third;
    logic [TOTAL_W-1:0]  count_total;
    logic [BAR_W-1:0]    bar_length;
  } out_item_t;

  typedef struct packed {
    logic clear_wr;
    logic load;
    logic decode;
    logic exec;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic readout;
  } dp_stat_t;

endpackage

/* design/mah_ram.sv */
module mah_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/mah_ctrl.sv */
module mah_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mah_pkg::dp_stat_t stat,
  output mah_pkg::dp_cmd_t  cmd,
  output logic              busy
);
  import mah_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = stat.readout ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd.clear_wr = (state_r == S_CLEAR);
    cmd.load     = (state_r == S_IDLE) && start;
    cmd.decode   = (state_r == S_DECODE);
    cmd.exec     = (state_r == S_EXEC);
    cmd.finish   = (state_r == S_FINISH);
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* design/mah_dp.sv */
module mah_dp #(
  parameter int unsigned GROUP_ENTRIES = mah_pkg::DEF_GROUP_ENTRIES,
  parameter int unsigned COUNTER_BITS  = mah_pkg::DEF_COUNTER_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mah_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mah_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  mah_pkg::in_item_t                 in_item,
  input  mah_pkg::dp_cmd_t                  cmd,
  output mah_pkg::dp_stat_t                 stat,
  output logic                              out_valid,
  output mah_pkg::out_item_t                out_item
);
  import mah_pkg::*;

  localparam int unsigned AW     = $clog2(GROUP_ENTRIES);
  localparam int unsigned WORD_W = 3 * COUNTER_BITS;

  function automatic logic [COUNT_W-1:0] clamp(input logic [COUNTER_BITS-1:0] v);
    logic [63:0] x;
    x = 64'(v);
    return (|x[63:COUNT_W]) ? FIELD_MAX : x[COUNT_W-1:0];
  endfunction

  function automatic logic [BAR_W-1:0] bar_of(input logic [TOTAL_W-1:0] t);
    logic [TOTAL_W-1:0] tl;
    logic [BAR_W-1:0]   n;
    logic               nb;
    tl = {t[TOTAL_W-2:0], 1'b0};
    n  = '0;
    nb = 1'b0;
    for (int i = 0; i < TOTAL_W; i++) begin
      if (t[i]) begin
        n  = BAR_W'(i + 1);
        nb = tl[i];
      end
    end
    if (n == '0) begin
      return '0;
    end
    return nb ? BAR_W'(2 * n) : BAR_W'(2 * n - 1);
  endfunction

  logic [ADDR_W-1:0]  win_start_r;
  logic [ADDR_W-1:0]  win_end_r;
  logic [SHIFT_W-1:0] shift_r;
  logic               wmode_r;

  logic [AW-1:0]      clr_idx_r;
  logic               kind_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [TYPE_W-1:0]  type_r;
  logic [AW-1:0]      group_idx_r;
  status_t            status_r;
  logic [SLOT_W-1:0]  slot_r;
  logic               count_en_r;
  logic [COUNT_W-1:0] cnt_a_r;
  logic [COUNT_W-1:0] cnt_b_r;
  logic [COUNT_W-1:0] cnt_c_r;
  logic [TOTAL_W-1:0] total_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic [ADDR_W-1:0]       group;
  logic                    beyond;
  logic                    outside;
  logic                    over;
  logic [TYPE_W-1:0]       eff_type;
  logic [TYPE_W-1:0]       code;
  logic                    unknown;
  logic [SLOT_W-1:0]       slot;
  status_t                 status;
  logic                    count_en;
  logic [WORD_W-1:0]       rdata;
  logic [WORD_W-1:0]       upd_word;
  logic [COUNTER_BITS-1:0] sel_cnt;
  logic [COUNT_W-1:0]      cl_a;
  logic [COUNT_W-1:0]      cl_b;
  logic [COUNT_W-1:0]      cl_c;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [WORD_W-1:0]       ram_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= '0;
      win_end_r   <= '1;
      shift_r     <= SHIFT_W'(2);
      wmode_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_WIN_START:   win_start_r <= cfg_wdata[ADDR_W-1:0];
        CFG_WIN_END:     win_end_r   <= cfg_wdata[ADDR_W-1:0];
        CFG_GROUP_SHIFT: shift_r     <= cfg_wdata[SHIFT_W-1:0];
        CFG_WIDTH_MODE:  wmode_r     <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    group    = addr_r >> shift_r;
    beyond   = (group >= ADDR_W'(GROUP_ENTRIES));
    outside  = (addr_r < win_start_r) || (addr_r > win_end_r);
    over     = (type_r > TYPE_LIMIT);
    eff_type = over ? '0 : type_r;
    code     = wmode_r ? (eff_type >> SIZE_SHIFT) : (eff_type & LOW_CODE_MASK);
    unknown  = 1'b0;
    case (code)
      CODE_FIRST:  slot = SLOT_FIRST;
      CODE_SECOND: slot = SLOT_SECOND;
      CODE_THIRD:  slot = SLOT_THIRD;
      default: begin
        slot    = SLOT_FIRST;
        unknown = 1'b1;
      end
    endcase
    count_en = 1'b0;
    if (kind_r == KIND_READOUT) begin
      status = beyond ? ST_BEYOND : ST_OK;
    end else if (outside) begin
      status = ST_OUTSIDE;
    end else if (beyond) begin
      status = ST_BEYOND;
    end else begin
      count_en = 1'b1;
      if (over) begin
        status = ST_OVER;
      end else if (unknown) begin
        status = ST_UNKNOWN;
      end else begin
        status = ST_OK;
      end
    end
  end

  always_comb begin
    upd_word = rdata;
    sel_cnt  = rdata[slot_r*COUNTER_BITS +: COUNTER_BITS];
    if (sel_cnt != '1) begin
      upd_word[slot_r*COUNTER_BITS +: COUNTER_BITS] = sel_cnt + 1'b1;
    end
  end

  always_comb begin
    if (status_r == ST_BEYOND) begin
      cl_a = '0;
      cl_b = '0;
      cl_c = '0;
    end else begin
      cl_a = clamp(rdata[0 +: COUNTER_BITS]);
      cl_b = clamp(rdata[COUNTER_BITS +: COUNTER_BITS]);
      cl_c = clamp(rdata[2*COUNTER_BITS +: COUNTER_BITS]);
    end
  end

  assign ram_we    = cmd.clear_wr || (cmd.exec && count_en_r);
  assign ram_waddr = cmd.clear_wr ? clr_idx_r : group_idx_r;
  assign ram_wdata = cmd.clear_wr ? '0 : upd_word;

  mah_ram #(
    .WIDTH (WORD_W),
    .DEPTH (GROUP_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.decode),
    .raddr (group[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_wr) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      out_valid_r <= (cmd.exec && (kind_r == KIND_RECORD)) || cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_item.kind;
      addr_r <= in_item.address;
      type_r <= in_item.access_type;
    end
    if (cmd.decode) begin
      group_idx_r <= group[AW-1:0];
      status_r    <= status;
      slot_r      <= slot;
      count_en_r  <= count_en;
    end
    if (cmd.exec) begin
      cnt_a_r <= cl_a;
      cnt_b_r <= cl_b;
      cnt_c_r <= cl_c;
      total_r <= TOTAL_W'(cl_a) + TOTAL_W'(cl_b) + TOTAL_W'(cl_c);
      if (kind_r == KIND_RECORD) begin
        out_r <= {status_r, {($bits(out_item_t) - STATUS_W){1'b0}}};
      end
    end
    if (cmd.finish) begin
      out_r <= {status_r, cnt_a_r, cnt_b_r, cnt_c_r, total_r, bar_of(total_r)};
    end
  end

  assign stat.clear_last = (clr_idx_r == AW'(GROUP_ENTRIES - 1));
  assign stat.readout    = (kind_r == KIND_READOUT);
  assign out_valid       = out_valid_r;
  assign out_item        = out_r;

endmodule

/* design/memory_access_histogram.sv */
// Counts memory accesses per address group and reads the counts back. One item is
// in flight at a time: an item is taken when start is high and busy is low, and busy
// stays high until the block can take the next one. A record item passes the load,
// decode (registered counter memory read) and execute (write-back, result) states.
// A readout registers its clamped counts and their sum in execute, then the full
// result with the bar length in a finish state. out_valid is high for exactly one
// cycle with the result on out_item, which cannot be held off. After reset a
// clearing pass zeroes the counter memory, one group per cycle, with busy high;
// configuration writes are taken at any time.
module memory_access_histogram #(
  parameter int unsigned GROUP_ENTRIES = mah_pkg::DEF_GROUP_ENTRIES,
  parameter int unsigned COUNTER_BITS  = mah_pkg::DEF_COUNTER_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  mah_pkg::in_item_t              in_item,
  output logic                           out_valid,
  output mah_pkg::out_item_t             out_item,
  input  logic                           cfg_we,
  input  logic [mah_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mah_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mah_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mah_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  mah_dp #(
    .GROUP_ENTRIES (GROUP_ENTRIES),
    .COUNTER_BITS  (COUNTER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted item");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!busy) && !busy |-> !out_valid)
    else $error("result appeared without an item in flight");

  a_flagged_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != ST_OK) |-> (out_item.count_total == '0))
    else $error("flagged result carries a nonzero total");

  a_bar_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.count_total == '0) |-> (out_item.bar_length == '0))
    else $error("zero total with nonzero bar length");

endmodule
